>>> sv/windowed_variance_pose_gate_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed variance pose gate
// Shared property wrappers with a common clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_VARIANCE_POSE_GATE_UNIT_ASSERT_SVH
`define WINDOWED_VARIANCE_POSE_GATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WVPG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WVPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/wvpg_pkg.sv
// ----------------------------------------------------------------------------
// Windowed variance pose gate package
// Field widths, register reset value and pose data types.
// ----------------------------------------------------------------------------
package wvpg_pkg;

    localparam int DATA_W     = 24;
    localparam int THR_W      = 40;
    localparam int WINDOW_DEF = 5;
    localparam int SQ_W       = 2 * DATA_W - 1;

    // 0.35 square metres in units of 2^-24.
    localparam logic [THR_W-1:0] THR_RESET = 40'd5872026;

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef struct packed {
        t_sample y;
        t_sample x;
    } t_xy;

    // x sits in the lowest bits, heading in the highest.
    typedef struct packed {
        t_sample heading;
        t_sample y;
        t_sample x;
    } t_pose;

    localparam int POSE_W  = $bits(t_pose);
    localparam int TDATA_W = ((POSE_W + 7) / 8) * 8;

endpackage

>>> sv/wvpg_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one x/y pair of the sliding window and passes it on at each shift.
// ----------------------------------------------------------------------------
module wvpg_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  wvpg_pkg::t_xy i_xy,
    output wvpg_pkg::t_xy o_xy
);
    import wvpg_pkg::*;

    t_xy r_xy;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_xy <= i_xy;
        end
    end

    assign o_xy = r_xy;

endmodule

>>> sv/wvpg_var_test.sv
// ----------------------------------------------------------------------------
// Variance threshold test
// Forms n*sumsq, sum^2 and threshold*n*(n-1) in one registered stage and
// compares them without division.
// ----------------------------------------------------------------------------
module wvpg_var_test #(
    parameter int  WINDOW  = wvpg_pkg::WINDOW_DEF,
    localparam int N_W     = $clog2(WINDOW + 1),
    localparam int K_W     = 2 * N_W,
    localparam int SUM_W   = wvpg_pkg::DATA_W + N_W,
    localparam int SUMSQ_W = wvpg_pkg::SQ_W + N_W
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [N_W-1:0]                i_cnt,
    input  logic [K_W-1:0]                i_k,
    input  logic signed [SUM_W-1:0]       i_sum,
    input  logic [SUMSQ_W-1:0]            i_sumsq,
    input  logic [wvpg_pkg::THR_W-1:0]    i_thr,
    output logic                          o_reach
);
    import wvpg_pkg::*;

    localparam int NSQ_W = SUMSQ_W + N_W;
    localparam int SSQ_W = 2 * SUM_W;
    localparam int RHS_W = THR_W + K_W;
    localparam int MAX_A = (NSQ_W > SSQ_W) ? NSQ_W : SSQ_W;
    localparam int CMP_W = (MAX_A > RHS_W) ? MAX_A : RHS_W;

    logic [NSQ_W-1:0] r_nsq;
    logic [SSQ_W-1:0] r_ssq;
    logic [RHS_W-1:0] r_rhs;
    logic             r_small;
    logic             r_thr_zero;
    logic [SUM_W-1:0] sum_mag;
    logic [CMP_W-1:0] lhs;

    // The magnitude of the most negative sum still fits as an unsigned value.
    assign sum_mag = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nsq      <= NSQ_W'(i_cnt) * NSQ_W'(i_sumsq);
            r_ssq      <= SSQ_W'(sum_mag) * SSQ_W'(sum_mag);
            r_rhs      <= RHS_W'(i_thr) * RHS_W'(i_k);
            r_small    <= (i_cnt < N_W'(2));
            r_thr_zero <= (i_thr == '0);
        end
    end

    assign lhs = (CMP_W'(r_nsq) >= CMP_W'(r_ssq)) ? (CMP_W'(r_nsq) - CMP_W'(r_ssq)) : '0;

    // With fewer than two values the variance is zero and only a zero limit is reached.
    assign o_reach = r_small ? r_thr_zero : (lhs >= CMP_W'(r_rhs));

endmodule

>>> sv/windowed_variance_pose_gate_unit.sv
// ----------------------------------------------------------------------------
// Windowed variance pose gate
// Passes a pose sample on, or zeros it when the x or y spread over the last
// WINDOW samples reaches the configured variance limit.
// ----------------------------------------------------------------------------
// Usage:
//   Poses arrive on the s_axis channel, one transfer per sample, and one
//   result per sample leaves on the m_axis channel in the same order.
//   A sample with x and y both zero is answered with zeros and leaves the
//   window untouched. Any other sample is shifted into a chain of WINDOW
//   cells; running sums of x, y and their squares follow each shift.
//   The user loads the limit via i_cfg_we / i_cfg_wdata while the block is idle (not enforced).
// Timing:
//   A sample passes from the accepting edge to m_axis_tvalid through five
//   registers: input stage, square stage, running-sum stage, product stage
//   and the output register.
//   One sample is taken every cycle unless back-pressure stalls the pipeline;
//   the running sums never stall it, so the throughput is one transfer per clock.
// Reset and back-pressure:
//   Reset empties the window, clears the sums and loads the default limit
//   (0.35 m^2). No clearing pass is needed. When m_axis_tready is low, stages
//   keep filling until the pipeline is full; s_axis_tready then drops.
// ----------------------------------------------------------------------------
module windowed_variance_pose_gate_unit #(
    parameter int WINDOW = wvpg_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wvpg_pkg::THR_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata fields from bit 0: pos_x[23:0], pos_y[47:24], heading[71:48]
    input  logic [wvpg_pkg::TDATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata fields from bit 0: out_x[23:0], out_y[47:24], out_heading[71:48]
    output logic [wvpg_pkg::TDATA_W-1:0]  m_axis_tdata
);
    import wvpg_pkg::*;

    localparam int N_W     = $clog2(WINDOW + 1);
    localparam int K_W     = 2 * N_W;
    localparam int SUM_W   = DATA_W + N_W;
    localparam int SUMSQ_W = SQ_W + N_W;

    function automatic logic [SQ_W-1:0] square_mag(t_sample v);
        logic [DATA_W-1:0] mag;
        mag = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
        return SQ_W'(mag) * SQ_W'(mag);
    endfunction

    // Handshake and stage advance.
    logic c_out, c4, c3, c2, c1;
    logic in_xfer, in_zero, shift;
    t_pose in_pose;

    // Configuration and window state.
    logic [THR_W-1:0] r_thr;
    logic [N_W-1:0]   r_fill;
    logic             full;
    t_xy              cell_q [WINDOW];

    // Stage 1.
    logic             r_v1, r_z1;
    t_pose            r_pose1;
    t_xy              r_old1;
    logic [N_W-1:0]   r_cnt1;

    // Stage 2.
    logic                      r_v2, r_z2;
    t_pose                     r_pose2;
    logic [N_W-1:0]            r_cnt2;
    logic [K_W-1:0]            r_k2;
    logic signed [SUM_W-1:0]   r_dx2, r_dy2;
    logic [SQ_W-1:0]           r_sqx2, r_sqy2, r_sqox2, r_sqoy2;

    // Stage 3 and running sums.
    logic                      r_v3, r_z3;
    t_pose                     r_pose3;
    logic [N_W-1:0]            r_cnt3;
    logic [K_W-1:0]            r_k3;
    logic signed [SUM_W-1:0]   r_acc_sum_x, r_acc_sum_y, n_sum_x, n_sum_y;
    logic [SUMSQ_W-1:0]        r_acc_sumsq_x, r_acc_sumsq_y, n_sumsq_x, n_sumsq_y;
    logic signed [SUM_W-1:0]   r_sum3_x, r_sum3_y;
    logic [SUMSQ_W-1:0]        r_sumsq3_x, r_sumsq3_y;
    logic                      upd3;

    // Stage 4 and output.
    logic             r_v4, r_z4;
    t_pose            r_pose4;
    logic             reach_x, reach_y;
    logic             r_ov;
    t_pose            r_opose;

    assign c_out = !r_ov || m_axis_tready;
    assign c4    = !r_v4 || c_out;
    assign c3    = !r_v3 || c4;
    assign c2    = !r_v2 || c3;
    assign c1    = !r_v1 || c2;

    assign s_axis_tready = c1;
    assign in_pose = t_pose'(s_axis_tdata[POSE_W-1:0]);
    assign in_xfer = s_axis_tvalid && c1;
    assign in_zero = (in_pose.x == '0) && (in_pose.y == '0);
    assign shift   = in_xfer && !in_zero;
    assign full    = (r_fill == N_W'(WINDOW));

    // Window chain: the newest pair enters cell 0, the oldest sits in the last cell.
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        t_xy cell_d;
        if (i == 0) begin : g_head
            assign cell_d = '{y: in_pose.y, x: in_pose.x};
        end else begin : g_link
            assign cell_d = cell_q[i-1];
        end
        wvpg_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (shift),
            .i_xy    (cell_d),
            .o_xy    (cell_q[i])
        );
    end

    assign upd3      = c3 && r_v2 && !r_z2;
    assign n_sum_x   = r_acc_sum_x + r_dx2;
    assign n_sum_y   = r_acc_sum_y + r_dy2;
    assign n_sumsq_x = r_acc_sumsq_x + SUMSQ_W'(r_sqx2) - SUMSQ_W'(r_sqox2);
    assign n_sumsq_y = r_acc_sumsq_y + SUMSQ_W'(r_sqy2) - SUMSQ_W'(r_sqoy2);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr         <= THR_RESET;
            r_fill        <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_v4          <= 1'b0;
            r_ov          <= 1'b0;
            r_acc_sum_x   <= '0;
            r_acc_sum_y   <= '0;
            r_acc_sumsq_x <= '0;
            r_acc_sumsq_y <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (shift && !full) begin
                r_fill <= r_fill + N_W'(1);
            end
            if (c1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (c2) begin
                r_v2 <= r_v1;
            end
            if (c3) begin
                r_v3 <= r_v2;
            end
            if (c4) begin
                r_v4 <= r_v3;
            end
            if (c_out) begin
                r_ov <= r_v4;
            end
            if (upd3) begin
                r_acc_sum_x   <= n_sum_x;
                r_acc_sum_y   <= n_sum_y;
                r_acc_sumsq_x <= n_sumsq_x;
                r_acc_sumsq_y <= n_sumsq_y;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (c1) begin
            r_pose1 <= in_pose;
            r_z1    <= in_zero;
            r_old1  <= full ? cell_q[WINDOW-1] : '0;
            r_cnt1  <= (in_zero || full) ? r_fill : (r_fill + N_W'(1));
        end
        if (c2) begin
            r_pose2 <= r_pose1;
            r_z2    <= r_z1;
            r_cnt2  <= r_cnt1;
            r_k2    <= K_W'(r_cnt1) * K_W'(r_cnt1 - N_W'(1));
            r_dx2   <= SUM_W'(r_pose1.x) - SUM_W'(r_old1.x);
            r_dy2   <= SUM_W'(r_pose1.y) - SUM_W'(r_old1.y);
            r_sqx2  <= square_mag(r_pose1.x);
            r_sqy2  <= square_mag(r_pose1.y);
            r_sqox2 <= square_mag(r_old1.x);
            r_sqoy2 <= square_mag(r_old1.y);
        end
        if (c3) begin
            r_pose3    <= r_pose2;
            r_z3       <= r_z2;
            r_cnt3     <= r_cnt2;
            r_k3       <= r_k2;
            r_sum3_x   <= upd3 ? n_sum_x : r_acc_sum_x;
            r_sum3_y   <= upd3 ? n_sum_y : r_acc_sum_y;
            r_sumsq3_x <= upd3 ? n_sumsq_x : r_acc_sumsq_x;
            r_sumsq3_y <= upd3 ? n_sumsq_y : r_acc_sumsq_y;
        end
        if (c4) begin
            r_pose4 <= r_pose3;
            r_z4    <= r_z3;
        end
        if (c_out) begin
            r_opose <= (r_z4 || reach_x || reach_y) ? '0 : r_pose4;
        end
    end

    wvpg_var_test #(.WINDOW(WINDOW)) u_test_x (
        .i_clk   (i_clk),
        .i_en    (c4),
        .i_cnt   (r_cnt3),
        .i_k     (r_k3),
        .i_sum   (r_sum3_x),
        .i_sumsq (r_sumsq3_x),
        .i_thr   (r_thr),
        .o_reach (reach_x)
    );

    wvpg_var_test #(.WINDOW(WINDOW)) u_test_y (
        .i_clk   (i_clk),
        .i_en    (c4),
        .i_cnt   (r_cnt3),
        .i_k     (r_k3),
        .i_sum   (r_sum3_y),
        .i_sumsq (r_sumsq3_y),
        .i_thr   (r_thr),
        .o_reach (reach_y)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = TDATA_W'(r_opose);

    `include "windowed_variance_pose_gate_unit_assert.svh"

    `WVPG_ASSERT_NEXT(a_zero_keeps_fill, i_clk, i_rst_n, in_xfer && in_zero, $stable(r_fill), "zero sample changed the fill count")
    `WVPG_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, shift && !full, r_fill == $past(r_fill) + N_W'(1), "fill count did not advance")
    `WVPG_ASSERT_NEXT(a_zero_result, i_clk, i_rst_n, c_out && r_v4 && r_z4, m_axis_tdata == '0, "zero sample gave a nonzero result")
    `WVPG_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, r_v1 && !r_z1, (r_cnt1 != '0) && (r_cnt1 <= N_W'(WINDOW)), "window count out of range")

endmodule

>>> tb/tb_windowed_variance_pose_gate_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the windowed variance pose gate
// Drives pose samples through the slave stream and compares every result on
// the master stream with an in-bench window model. A short table covers zero
// poses, field extremes and the limit at zero and at full scale. Random
// phases follow, mostly drifting tracks with noise near the limit, mixed with
// outliers and raw random poses, under several limit settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_windowed_variance_pose_gate_unit;
    import wvpg_pkg::*;

    localparam int WIN         = WINDOW_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 10;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 205;

    localparam t_sample S_MAX = 24'sh7FFFFF;
    localparam t_sample S_MIN = 24'sh800000;

    typedef enum logic {
        ROW_POSE,
        ROW_LIMIT
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_pose            pose;
        bit               typed;
        t_pose            want;
        logic [THR_W-1:0] limit;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [THR_W-1:0]   i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;

    windowed_variance_pose_gate_unit #(
        .WINDOW(WIN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Window model state.
    t_sample          win_x [WIN];
    t_sample          win_y [WIN];
    int               fill_n;
    int               wr_ptr;
    longint           sum_x;
    longint           sum_y;
    longint           sq_x;
    longint           sq_y;
    logic [THR_W-1:0] limit_now;

    t_pose awaited_poses [$];
    t_row  rows [$];

    int send_idle_pct;
    int recv_stall_pct;
    int n_errors;
    int n_sent;
    int n_gated;
    int n_zero_pose;
    int n_limits;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_pose pose_of(t_sample x, t_sample y, t_sample h);
        t_pose p;
        p.x       = x;
        p.y       = y;
        p.heading = h;
        return p;
    endfunction

    function automatic t_row row_pose(t_sample x, t_sample y, t_sample h);
        return '{ROW_POSE, pose_of(x, y, h), 1'b0, '0, '0};
    endfunction

    function automatic t_row row_typed(t_sample x, t_sample y, t_sample h, t_pose want);
        return '{ROW_POSE, pose_of(x, y, h), 1'b1, want, '0};
    endfunction

    function automatic t_row row_limit(logic [THR_W-1:0] v);
        return '{ROW_LIMIT, '0, 1'b0, '0, v};
    endfunction

    // Sample variance test without division: n*sumsq - sum^2 >= limit*n*(n-1).
    function automatic bit spread_reaches(int n, longint s, longint sq);
        longint lhs;
        if (n < 2)
            return limit_now == '0;
        lhs = longint'(n) * sq - s * s;
        if (lhs < 0)
            lhs = 0;
        return lhs >= longint'(limit_now) * n * (n - 1);
    endfunction

    function automatic t_pose predict_gate(t_pose p);
        int k;
        if (p.x == '0 && p.y == '0) begin
            n_zero_pose++;
            return '0;
        end
        k = wr_ptr;
        if (fill_n >= WIN) begin
            sum_x -= longint'(win_x[k]);
            sum_y -= longint'(win_y[k]);
            sq_x  -= longint'(win_x[k]) * longint'(win_x[k]);
            sq_y  -= longint'(win_y[k]) * longint'(win_y[k]);
        end else begin
            fill_n++;
        end
        win_x[k] = p.x;
        win_y[k] = p.y;
        sum_x += longint'(p.x);
        sum_y += longint'(p.y);
        sq_x  += longint'(p.x) * longint'(p.x);
        sq_y  += longint'(p.y) * longint'(p.y);
        wr_ptr = (k + 1) % WIN;
        if (spread_reaches(fill_n, sum_x, sq_x) || spread_reaches(fill_n, sum_y, sq_y)) begin
            n_gated++;
            return '0;
        end
        return p;
    endfunction

    task automatic send_pose(t_pose p, bit typed, t_pose want);
        t_pose guess;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        guess = predict_gate(p);
        awaited_poses.push_back(typed ? want : guess);
        n_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (awaited_poses.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [THR_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        limit_now = v;
        n_limits++;
    endtask

    // Result side: random back-pressure and comparison against the oldest
    // expectation.
    initial begin
        t_pose got;
        t_pose want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[POSE_W-1:0];
                if (awaited_poses.size() == 0) begin
                    $display("%0t ns: transfer with nothing expected, got x %0d y %0d h %0d",
                             $time, got.x, got.y, got.heading);
                    n_errors++;
                end else begin
                    want = awaited_poses.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t ns: out_x expected %0d got %0d", $time, want.x, got.x);
                        n_errors++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t ns: out_y expected %0d got %0d", $time, want.y, got.y);
                        n_errors++;
                    end
                    if (got.heading !== want.heading) begin
                        $display("%0t ns: out_heading expected %0d got %0d",
                                 $time, want.heading, got.heading);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("windowed_variance_pose_gate_unit: mismatch");
            $finish;
        end
    end

    initial begin
        t_pose  p;
        int     r;
        int     cx;
        int     cy;
        int     spread;
        int     jump;
        t_sample tx;
        t_sample ty;
        logic [THR_W-1:0] lim;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        cycles         = 0;
        n_errors       = 0;
        n_sent         = 0;
        n_gated        = 0;
        n_zero_pose    = 0;
        n_limits       = 0;
        fill_n         = 0;
        wr_ptr         = 0;
        sum_x          = 0;
        sum_y          = 0;
        sq_x           = 0;
        sq_y           = 0;
        limit_now      = THR_RESET;
        send_idle_pct  = 6;
        recv_stall_pct = 82;
        for (int k = 0; k < WIN; k++) begin
            win_x[k] = '0;
            win_y[k] = '0;
        end
        cx     = 0;
        cy     = 0;
        spread = 8000;

        // The first sample holds alone in the window, so it passes under the
        // default limit. Five equal samples leave zero spread.
        rows.push_back(row_typed(100, 200, 300, pose_of(100, 200, 300)));
        rows.push_back(row_typed(0, 0, 12345, '0));
        rows.push_back(row_pose(110, 190, -5));
        rows.push_back(row_typed(S_MIN, S_MAX, S_MAX, '0));
        rows.push_back(row_pose(S_MAX, S_MIN, S_MIN));
        rows.push_back(row_typed(0, 0, S_MIN, '0));
        rows.push_back(row_pose(0, 1, 1));
        rows.push_back(row_pose(-1, 0, -1));
        repeat (4) rows.push_back(row_pose(1000, 2000, 777));
        rows.push_back(row_typed(1000, 2000, 777, pose_of(1000, 2000, 777)));
        rows.push_back(row_limit('0));
        rows.push_back(row_typed(1000, 2000, 777, '0));
        rows.push_back(row_typed(0, 0, 5, '0));
        rows.push_back(row_limit('1));
        rows.push_back(row_pose(S_MIN, S_MIN, 1));
        rows.push_back(row_pose(S_MAX, S_MAX, -1));
        rows.push_back(row_pose(0, S_MIN, S_MAX));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_LIMIT) begin
                wait_idle();
                set_limit(rows[i].limit);
            end else begin
                send_pose(rows[i].pose, rows[i].typed, rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            if (ph < 2) begin
                send_idle_pct  = 6;
                recv_stall_pct = 82;
            end else if (ph < 4) begin
                send_idle_pct  = 82;
                recv_stall_pct = 6;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (ph)
                0:       lim = THR_RESET;
                1:       lim = THR_W'($urandom_range(1, 1 << 26));
                2:       lim = THR_W'(1);
                3:       lim = '1;
                4:       lim = THR_W'({$urandom, $urandom});
                default: lim = THR_W'($urandom_range(1000000, 20000000));
            endcase
            set_limit(lim);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2)
                    wait_idle();
                if (i % 40 == 0) begin
                    spread = $urandom_range(0, 16000);
                    if ($urandom_range(0, 3) == 0) begin
                        cx = int'($urandom_range(0, 16000000)) - 8000000;
                        cy = int'($urandom_range(0, 16000000)) - 8000000;
                    end
                end
                cx += int'($urandom_range(0, 64)) - 32;
                cy += int'($urandom_range(0, 64)) - 32;
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    p = pose_of(0, 0, t_sample'($urandom));
                end else if (r < 12) begin
                    // One axis at zero still enters the window.
                    tx = t_sample'($urandom);
                    p  = r[0] ? pose_of(0, tx, t_sample'($urandom))
                              : pose_of(tx, 0, t_sample'($urandom));
                end else if (r < 22) begin
                    p = pose_of(t_sample'($urandom), t_sample'($urandom), t_sample'($urandom));
                end else if (r < 28) begin
                    jump = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                    p = pose_of(t_sample'(cx + jump), t_sample'(cy - jump),
                                t_sample'($urandom));
                end else begin
                    tx = t_sample'(cx + int'($urandom_range(0, spread)) - spread / 2);
                    ty = t_sample'(cy + int'($urandom_range(0, spread)) - spread / 2);
                    p  = pose_of(tx, ty, t_sample'($urandom));
                end
                send_pose(p, 1'b0, '0);
            end
        end

        wait_idle();
        $display("Run covered %0d samples under %0d limit settings.", n_sent, n_limits);
        $display("%0d passed through, %0d gated to zeros, %0d zero poses answered.",
                 n_sent - n_gated - n_zero_pose, n_gated, n_zero_pose);
        if (n_errors == 0) begin
            $display("windowed_variance_pose_gate_unit: match");
        end else begin
            $display("windowed_variance_pose_gate_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> windowed_variance_pose_gate_unit.f
+incdir+sv
sv/wvpg_pkg.sv
sv/wvpg_cell.sv
sv/wvpg_var_test.sv
sv/windowed_variance_pose_gate_unit.sv
tb/tb_windowed_variance_pose_gate_unit.sv
